// ===== hw/rtl/light_change_logger_defines.svh =====
// assertion macros for the light change logger
`ifndef LIGHT_CHANGE_LOGGER_DEFINES_SVH
`define LIGHT_CHANGE_LOGGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lcl_pkg.sv =====
// shared constants, codes and control structs of the light change logger
package lcl_pkg;

  localparam int LOG_PAIRS = 10;
  localparam logic [11:0] THRESHOLD_RESET = 12'd200;
  localparam logic [7:0] SECONDS_PER_TICK = 8'd10;

  // floor(n / 125000) == (n * RECIP_MULT) >> RECIP_SHIFT for every 21-bit n
  localparam logic [21:0] RECIP_MULT = 22'd2199024;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_W = 43;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_PWM   = 2'd0,
    KIND_STORE = 2'd1,
    KIND_DUMP  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic log_write;
    logic emit_pwm;
    logic walk_start;
    logic walk_store;
    logic emit_byte;
    logic copy;
    logic emit_end;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      change_hit;
    logic      full;
    logic      pending;
    logic      out_free;
    logic      walk_last;
    logic      walk_store;
  } dp_sts_t;

endpackage

// ===== hw/rtl/lcl_if.sv =====
// valid/ready channel interfaces for samples, results and configuration
interface lcl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] sample;
  logic [20:0] timer_count;

  modport source (output valid, cmd, sample, timer_count, input ready);
  modport sink (input valid, cmd, sample, timer_count, output ready);
endinterface

interface lcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] value;
  logic        last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

interface lcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] change_threshold;

  modport source (output valid, change_threshold, input ready);
  modport sink (input valid, change_threshold, output ready);
endinterface

// ===== hw/rtl/lcl_ctrl.sv =====
// controller state machine of the light change logger
module lcl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcl_pkg::dp_sts_t sts,
  output lcl_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PWM,
    S_WALK,
    S_COPY,
    S_END
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.code)
          lcl_pkg::CMD_SAMPLE: begin
            state_next = sts.change_hit ? S_PWM : S_IDLE;
          end
          lcl_pkg::CMD_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_IDLE;
          end
          lcl_pkg::CMD_DUMP: begin
            if (sts.pending) begin
              cmd.walk_start = 1'b1;
              state_next     = S_WALK;
            end else begin
              state_next = S_END;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_PWM: begin
        if (sts.out_free) begin
          cmd.emit_pwm  = 1'b1;
          cmd.log_write = 1'b1;
          if (sts.full) begin
            cmd.walk_start = 1'b1;
            cmd.walk_store = 1'b1;
            state_next     = S_WALK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.walk_last) begin
            state_next = S_COPY;
          end
        end
      end
      S_COPY: begin
        // newest percentage becomes the head of the next batch
        cmd.copy   = 1'b1;
        state_next = sts.walk_store ? S_IDLE : S_END;
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/lcl_dpath.sv =====
// datapath of the light change logger: compare, log arrays, walk counter, output register
module lcl_dpath #(
  parameter int LOG_PAIRS = lcl_pkg::LOG_PAIRS
) (
  input  logic             clk,
  input  logic             rst,
  input  lcl_pkg::dp_cmd_t cmd,
  output lcl_pkg::dp_sts_t sts,
  input  logic [1:0]       in_cmd,
  input  logic [11:0]      in_sample,
  input  logic [20:0]      in_count,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [11:0]      out_value,
  output logic             out_last,
  input  logic             out_ready
);

  localparam int IW = (LOG_PAIRS > 1) ? $clog2(LOG_PAIRS) : 1;
  localparam int FW = $clog2(LOG_PAIRS + 1);
  localparam logic [FW-1:0] FILL_ONE = FW'(1);
  localparam logic [FW-1:0] FILL_TWO = FW'(2);
  localparam logic [FW-1:0] FILL_FULL = FW'(LOG_PAIRS);
  localparam logic [IW-1:0] STORE_END = IW'(LOG_PAIRS - 2);

  logic [11:0]        threshold;
  logic [11:0]        last_accepted;
  logic [7:0]         ticks;
  logic [FW-1:0]      fill;
  lcl_pkg::cmd_code_t cur_cmd;
  logic [11:0]        cur_sample;
  logic [4:0]         quot;
  logic [6:0]         percent_log [LOG_PAIRS];
  logic [7:0]         seconds_log [LOG_PAIRS];
  logic [IW-1:0]      walk_idx;
  logic               walk_half;
  logic [IW-1:0]      walk_end;
  logic               walk_store;
  lcl_pkg::kind_t     kind_r;

  logic [lcl_pkg::PROD_W-1:0] prod;
  logic [11:0]   diff;
  logic [16:0]   pct_sum;
  logic [6:0]    pct;
  logic [7:0]    tick_secs;
  logic [7:0]    secs;
  logic [FW-1:0] fill_m1;
  logic [FW-1:0] fill_m2;
  logic          full;
  logic          walk_last;
  logic          out_free;
  logic [11:0]   byte_value;

  assign prod = lcl_pkg::PROD_W'(in_count) * lcl_pkg::PROD_W'(lcl_pkg::RECIP_MULT);

  assign diff = (cur_sample >= last_accepted) ? cur_sample - last_accepted
                                              : last_accepted - cur_sample;

  // percentage is 100 - ceil(v * 25 / 1024)
  assign pct_sum = (17'(cur_sample) * 17'd25) + 17'd1023;
  assign pct = 7'd100 - pct_sum[16:10];

  // only the low byte of ticks * 10 survives the modulo
  assign tick_secs = ticks * lcl_pkg::SECONDS_PER_TICK;
  assign secs = tick_secs + 8'(quot);

  assign fill_m1   = fill - FILL_ONE;
  assign fill_m2   = fill - FILL_TWO;
  assign full      = (fill == FILL_FULL);
  assign walk_last = walk_half && (walk_idx == walk_end);
  assign out_free  = !out_valid || out_ready;

  assign byte_value = walk_half ? 12'(seconds_log[walk_idx]) : 12'(percent_log[walk_idx]);

  assign sts.code       = cur_cmd;
  assign sts.change_hit = (diff > threshold);
  assign sts.full       = full;
  assign sts.pending    = (fill != FILL_ONE);
  assign sts.out_free   = out_free;
  assign sts.walk_last  = walk_last;
  assign sts.walk_store = walk_store;

  assign out_kind = kind_r;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= lcl_pkg::THRESHOLD_RESET;
      last_accepted <= '0;
      ticks         <= '0;
      fill          <= FILL_ONE;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      if (cmd.tick) begin
        ticks <= ticks + 8'd1;
      end
      if (cmd.log_write) begin
        last_accepted <= cur_sample;
        ticks         <= '0;
        fill          <= full ? FILL_ONE : fill + FILL_ONE;
      end
      if (cmd.copy || cmd.emit_end) begin
        fill <= FILL_ONE;
      end
      if (cmd.emit_pwm || cmd.emit_byte || cmd.emit_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_cmd    <= lcl_pkg::cmd_code_t'(in_cmd);
      cur_sample <= in_sample;
      quot       <= 5'(prod >> lcl_pkg::RECIP_SHIFT);
    end
    if (cmd.walk_start) begin
      walk_idx   <= '0;
      walk_half  <= 1'b0;
      walk_store <= cmd.walk_store;
      walk_end   <= cmd.walk_store ? STORE_END : fill_m2[IW-1:0];
    end else if (cmd.emit_byte) begin
      walk_half <= !walk_half;
      if (walk_half) begin
        walk_idx <= walk_idx + IW'(1);
      end
    end
    if (cmd.emit_pwm) begin
      kind_r    <= lcl_pkg::KIND_PWM;
      out_value <= cur_sample;
      out_last  <= !full;
    end else if (cmd.emit_byte) begin
      kind_r    <= walk_store ? lcl_pkg::KIND_STORE : lcl_pkg::KIND_DUMP;
      out_value <= byte_value;
      out_last  <= walk_store && walk_last;
    end else if (cmd.emit_end) begin
      kind_r    <= lcl_pkg::KIND_END;
      out_value <= '0;
      out_last  <= 1'b1;
    end
  end

  // log arrays, only the head entries have a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      percent_log[0] <= '0;
      seconds_log[0] <= '0;
    end else begin
      if (cmd.copy) begin
        percent_log[0] <= percent_log[walk_idx];
      end else if (cmd.log_write && !full) begin
        percent_log[fill[IW-1:0]] <= pct;
      end
      if (cmd.log_write) begin
        seconds_log[fill_m1[IW-1:0]] <= secs;
      end
    end
  end

endmodule

// ===== hw/rtl/light_change_logger.sv =====
// light change logger: sample compare, pwm update, level logging and dump
// a changed sample emits its pwm item and is logged; a full log then walks out its stored
// pairs and copies the head; a dump walks the pending pairs, copies and emits the end item;
// one item in flight; one result per cycle unless the receiver stalls, rate set by the
// controller sequence and the single output register
// reset (rst, synchronous): threshold 200, fill one, first log entry zero, no clearing pass
`include "light_change_logger_defines.svh"

module light_change_logger #(
  parameter int LOG_PAIRS = lcl_pkg::LOG_PAIRS
) (
  input logic       clk,
  input logic       rst,
  lcl_in_if.sink    samples,
  lcl_out_if.source results,
  lcl_cfg_if.sink   cfg
);

  lcl_pkg::dp_cmd_t dp_cmd;
  lcl_pkg::dp_sts_t dp_sts;

  assign cfg.ready = 1'b1;

  lcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  lcl_dpath #(
    .LOG_PAIRS (LOG_PAIRS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .in_cmd    (samples.cmd),
    .in_sample (samples.sample),
    .in_count  (samples.timer_count),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_data  (cfg.change_threshold),
    .out_valid (results.valid),
    .out_kind  (results.kind),
    .out_value (results.value),
    .out_last  (results.last),
    .out_ready (results.ready)
  );

  `LCL_ASSERT_NEXT(a_busy_after_accept, samples.valid && samples.ready, !samples.ready, "input taken while item in flight")
  `LCL_ASSERT_NOW(a_result_while_busy, $rose(results.valid), !$past(samples.ready), "result raised from idle")
  `LCL_ASSERT_NOW(a_end_closes_item, results.valid && (results.kind == lcl_pkg::KIND_END), results.last && (results.value == 12'd0), "dump end not final")

endmodule

// ===== tb/sv/tb_top.sv =====
// light change logger testbench: directed and random items checked against a level-log predictor
module tb_top;
  import lcl_pkg::*;

  localparam int LOG_DEPTH = LOG_PAIRS + 1;
  localparam int QUIET_CYCLES = 12;
  localparam int END_CYCLES = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_TIMER = 1249999;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] value;
    logic        last;
  } logger_out_t;

  logic clk;
  logic rst;

  lcl_in_if  in_if ();
  lcl_out_if res_if ();
  lcl_cfg_if cfg_if ();

  light_change_logger dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  // predictor copy of the logger state
  logic [11:0] lvl_thresh;
  logic [11:0] lvl_last;
  logic [6:0]  pct_log [LOG_DEPTH];
  logic [7:0]  sec_log [LOG_DEPTH];
  int          fill_idx;
  logic [15:0] lvl_ticks;
  logger_out_t logger_out_q [$];

  // stimulus side view of the threshold and the last accepted level
  int gen_thresh;
  int gen_last;

  int   err_count;
  int   quiet_cycles;
  bit   gaps_on;
  bit   stall_on;
  bit   long_hold;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] rand12();
    logic [31:0] w;
    w = $urandom_range(0, 4095);
    return w[11:0];
  endfunction

  function automatic logic [20:0] pick_timer();
    int r;
    logic [31:0] w;
    r = $urandom_range(0, 9);
    if (r == 0) w = 0;
    else if (r == 1) w = MAX_TIMER;
    else w = $urandom_range(0, MAX_TIMER);
    return w[20:0];
  endfunction

  // level that moves by more than the threshold, random if none exists
  function automatic logic [11:0] pick_changed(int from, int th);
    int hi_room;
    int lo_room;
    logic [31:0] w;
    hi_room = 4095 - from - th;
    lo_room = from - th;
    if (hi_room <= 0 && lo_room <= 0) return rand12();
    if (lo_room <= 0 || (hi_room > 0 && $urandom_range(0, 1) == 1))
      w = $urandom_range(from + th + 1, 4095);
    else
      w = $urandom_range(0, from - th - 1);
    return w[11:0];
  endfunction

  // level within the threshold of the current one
  function automatic logic [11:0] pick_close(int from, int th);
    int lo;
    int hi;
    logic [31:0] w;
    lo = (from - th < 0) ? 0 : from - th;
    hi = (from + th > 4095) ? 4095 : from + th;
    w = $urandom_range(lo, hi);
    return w[11:0];
  endfunction

  function automatic void queue_result(kind_t k, logic [11:0] v);
    logger_out_t r;
    r.kind = k;
    r.value = v;
    r.last = 1'b0;
    logger_out_q.push_back(r);
  endfunction

  task automatic apply_light_item(logic [1:0] c, logic [11:0] smp, logic [20:0] cnt);
    int first;
    int idx;
    int diff;
    logic [31:0] pct;
    logic [31:0] secs;
    logger_out_t tail;
    first = logger_out_q.size();
    case (c)
      CMD_SAMPLE: begin
        diff = (smp > lvl_last) ? int'({20'b0, smp}) - int'({20'b0, lvl_last})
                                : int'({20'b0, lvl_last}) - int'({20'b0, smp});
        if (diff > int'({20'b0, lvl_thresh})) begin
          lvl_last = smp;
          queue_result(KIND_PWM, smp);
          idx = (fill_idx < 1) ? 1 : ((fill_idx >= LOG_DEPTH) ? LOG_DEPTH - 1 : fill_idx);
          // brightness percent rounds the scaled reading up
          pct = 32'd100 - ((({20'b0, smp} * 32'd25) + 32'd1023) >> 10);
          secs = ({16'b0, lvl_ticks} * 32'd10) + ({11'b0, cnt} / 32'd125000);
          pct_log[idx] = pct[6:0];
          sec_log[idx - 1] = secs[7:0];
          fill_idx = idx + 1;
          if (fill_idx >= LOG_DEPTH) begin
            for (int i = 0; i + 1 < LOG_PAIRS; i++) begin
              queue_result(KIND_STORE, {5'b0, pct_log[i]});
              queue_result(KIND_STORE, {4'b0, sec_log[i]});
            end
            pct_log[0] = pct_log[LOG_PAIRS - 1];
            fill_idx = 1;
          end
          lvl_ticks = 16'd0;
        end
      end
      CMD_TICK: lvl_ticks = lvl_ticks + 16'd1;
      CMD_DUMP: begin
        if (fill_idx > 1) begin
          for (int i = 0; i + 1 < fill_idx; i++) begin
            queue_result(KIND_DUMP, {5'b0, pct_log[i]});
            queue_result(KIND_DUMP, {4'b0, sec_log[i]});
          end
          pct_log[0] = pct_log[fill_idx - 1];
        end
        fill_idx = 1;
        queue_result(KIND_END, 12'd0);
      end
      default: ;
    endcase
    if (logger_out_q.size() > first) begin
      tail = logger_out_q.pop_back();
      tail.last = 1'b1;
      logger_out_q.push_back(tail);
    end
  endtask

  // results are checked before this edge's item is predicted
  always @(posedge clk) begin
    logger_out_t want;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (logger_out_q.size() == 0) begin
          err_count++;
          $error("unexpected result: kind %0d value %0d last %0d",
                 res_if.kind, res_if.value, res_if.last);
        end else begin
          want = logger_out_q.pop_front();
          if (res_if.kind !== want.kind) begin
            err_count++;
            $error("kind mismatch: expected %0d, actual %0d", want.kind, res_if.kind);
          end
          if (res_if.value !== want.value) begin
            err_count++;
            $error("value mismatch: expected %0d, actual %0d", want.value, res_if.value);
          end
          if (res_if.last !== want.last) begin
            err_count++;
            $error("last mismatch: expected %0d, actual %0d", want.last, res_if.last);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready)
        lvl_thresh = cfg_if.change_threshold;
      if (in_if.valid && in_if.ready)
        apply_light_item(in_if.cmd, in_if.sample, in_if.timer_count);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    int g;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        g = pick_gap();
        if (g == 0) g = 1;
        res_if.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // valid stays high between back-to-back items
  task automatic send_item(cmd_code_t c, logic [11:0] s, logic [20:0] t);
    int gap;
    int diff;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= c;
    in_if.sample <= s;
    in_if.timer_count <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (c == CMD_SAMPLE) begin
      diff = int'({20'b0, s}) - gen_last;
      if (diff < 0) diff = -diff;
      if (diff > gen_thresh) gen_last = int'({20'b0, s});
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (logger_out_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(int th);
    logic [31:0] w;
    w = th;
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.change_threshold <= w[11:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    gen_thresh = th;
  endtask

  task automatic test_empty_dump();
    send_item(CMD_DUMP, rand12(), pick_timer());
  endtask

  task automatic test_unused_cmd();
    send_item(CMD_UNUSED, 12'd4095, 21'd1249999);
  endtask

  // reset threshold: a change of exactly the threshold is not enough
  task automatic test_small_change();
    send_item(CMD_SAMPLE, 12'd200, pick_timer());
    send_item(CMD_SAMPLE, 12'd201, pick_timer());
    send_item(CMD_SAMPLE, 12'd1, pick_timer());
  endtask

  task automatic test_extremes();
    send_item(CMD_SAMPLE, 12'd4095, 21'd1249999);
    send_item(CMD_SAMPLE, 12'd0, 21'd0);
    send_item(CMD_SAMPLE, 12'd4095, pick_timer());
  endtask

  // 25 ticks plus 9 s of count pushes the seconds byte past 255
  task automatic test_seconds_wrap();
    repeat (25) send_item(CMD_TICK, rand12(), pick_timer());
    send_item(CMD_SAMPLE, pick_changed(gen_last, gen_thresh), 21'd1249999);
  endtask

  task automatic test_dump_pending();
    send_item(CMD_DUMP, rand12(), pick_timer());
    send_item(CMD_DUMP, rand12(), pick_timer());
  endtask

  task automatic test_full_log();
    set_threshold(0);
    repeat (13) send_item(CMD_SAMPLE, pick_changed(gen_last, gen_thresh), pick_timer());
    send_item(CMD_DUMP, rand12(), pick_timer());
  endtask

  task automatic test_output_backpressure();
    set_threshold(100);
    gaps_on = 1'b0;
    long_hold = 1'b1;
    repeat (8) send_item(CMD_SAMPLE, pick_changed(gen_last, gen_thresh), pick_timer());
    send_item(CMD_DUMP, rand12(), pick_timer());
    settle();
  endtask

  task automatic send_random_item();
    int r;
    int burst;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_item(CMD_SAMPLE, pick_changed(gen_last, gen_thresh), pick_timer());
    end else if (r < 72) begin
      send_item(CMD_SAMPLE, pick_close(gen_last, gen_thresh), pick_timer());
    end else if (r < 84) begin
      send_item(CMD_TICK, rand12(), pick_timer());
    end else if (r < 87) begin
      burst = $urandom_range(15, 30);
      repeat (burst) send_item(CMD_TICK, rand12(), pick_timer());
    end else if (r < 92) begin
      send_item(CMD_DUMP, rand12(), pick_timer());
    end else if (r < 96) begin
      send_item(CMD_SAMPLE, rand12(), pick_timer());
    end else begin
      send_item(CMD_UNUSED, rand12(), pick_timer());
    end
  endtask

  task automatic test_random_levels();
    int th;
    int count;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: th = 0;
        1: th = $urandom_range(1, 255);
        2: th = 4095;
        3: th = $urandom_range(0, 4095);
        4: th = $urandom_range(256, 1500);
        default: th = int'({20'b0, THRESHOLD_RESET});
      endcase
      set_threshold(th);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      count = (th == 4095) ? 12 : 45;
      repeat (count) send_random_item();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_SAMPLE;
    in_if.sample <= 12'd0;
    in_if.timer_count <= 21'd0;
    cfg_if.valid <= 1'b0;
    cfg_if.change_threshold <= 12'd0;
    lvl_thresh = THRESHOLD_RESET;
    lvl_last = 12'd0;
    pct_log[0] = 7'd0;
    sec_log[0] = 8'd0;
    fill_idx = 1;
    lvl_ticks = 16'd0;
    gen_thresh = int'({20'b0, THRESHOLD_RESET});
    gen_last = 0;
    err_count = 0;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    long_hold = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_dump();
    test_unused_cmd();
    test_small_change();
    test_extremes();
    test_seconds_wrap();
    test_dump_pending();
    test_full_log();
    test_output_backpressure();
    test_random_levels();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (logger_out_q.size() != 0) begin
      err_count++;
      $error("%0d expected results never arrived", logger_out_q.size());
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== light_change_logger.f =====
+incdir+hw/rtl
hw/rtl/lcl_pkg.sv
hw/rtl/lcl_if.sv
hw/rtl/lcl_ctrl.sv
hw/rtl/lcl_dpath.sv
hw/rtl/light_change_logger.sv
tb/sv/tb_top.sv
